// File: rtl/core/tps_pkg.sv
// Shared types and constants of the text pretokenizer splitter.
package tps_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CLASS_W       = 3;
  localparam int unsigned SHOWN_COUNT_W = 16;

  // Class of one text byte, as shown on the result channel.
  typedef enum logic [CLASS_W-1:0] {
    CLS_SPACE = 3'd0,
    CLS_CR    = 3'd1,
    CLS_LF    = 3'd2,
    CLS_WORD  = 3'd3,
    CLS_OTHER = 3'd4
  } byte_class_t;

  // Kind of chunk left open by the bytes seen so far.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SPACES = 2'd1,
    KIND_WORD   = 2'd2,
    KIND_CR     = 2'd3
  } chunk_kind_t;

  // Request from the top level to the chunk tracker for one item.
  typedef struct packed {
    logic        advance;
    byte_class_t cls;
    logic        last;
  } trk_req_t;

  // Response of the chunk tracker for the item presented to it.
  typedef struct packed {
    logic        first;
    chunk_kind_t kind;
  } trk_rsp_t;

endpackage

// File: rtl/core/tps_if.sv
// Valid/ready channel interfaces for text bytes and marked result bytes.
interface tps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_of_text;

  modport source (output valid, output text_byte, output last_of_text, input ready);
  modport sink   (input valid, input text_byte, input last_of_text, output ready);
endinterface

interface tps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        first_of_chunk;
  logic [2:0]  byte_class;
  logic [15:0] chunk_total;
  logic        text_done;

  modport source (output valid, output byte_out, output first_of_chunk,
                  output byte_class, output chunk_total, output text_done,
                  input ready);
  modport sink   (input valid, input byte_out, input first_of_chunk,
                  input byte_class, input chunk_total, input text_done,
                  output ready);
endinterface

// File: rtl/core/tps_classifier.sv
// Byte classifier: space/tab, CR, LF, word byte or other.
module tps_classifier (
  input  logic [tps_pkg::BYTE_W-1:0] byte_i,
  output tps_pkg::byte_class_t       cls_o
);
  import tps_pkg::*;

  logic is_lower;
  logic is_upper;
  logic is_digit;

  assign is_lower = (byte_i >= 8'h61) && (byte_i <= 8'h7A);
  assign is_upper = (byte_i >= 8'h41) && (byte_i <= 8'h5A);
  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);

  always_comb begin
    priority if ((byte_i == 8'h20) || (byte_i == 8'h09)) begin
      cls_o = CLS_SPACE;
    end else if (byte_i == 8'h0D) begin
      cls_o = CLS_CR;
    end else if (byte_i == 8'h0A) begin
      cls_o = CLS_LF;
    end else if (is_lower || is_upper || is_digit || byte_i[7]) begin
      cls_o = CLS_WORD;
    end else begin
      cls_o = CLS_OTHER;
    end
  end

endmodule

// File: rtl/core/tps_chunk_tracker.sv
// Chunk tracker: open chunk kind and saturating chunk counter.
module tps_chunk_tracker #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tps_pkg::trk_req_t      req_i,
  output tps_pkg::trk_rsp_t      rsp_o,
  output logic [COUNT_WIDTH-1:0] count_o
);
  import tps_pkg::*;

  chunk_kind_t            kind_r;
  chunk_kind_t            kind_nxt;
  chunk_kind_t            kind_follow;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH-1:0] count_shown;
  logic                   first;

  // Kind left open after a byte that starts a chunk or ends a space run.
  function automatic chunk_kind_t kind_after(byte_class_t c);
    chunk_kind_t k;
    unique case (c)
      CLS_SPACE: k = KIND_SPACES;
      CLS_CR:    k = KIND_CR;
      CLS_WORD:  k = KIND_WORD;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  always_comb begin
    kind_follow = kind_after(req_i.cls);
    unique case (kind_r)
      KIND_SPACES: begin
        first    = 1'b0;
        kind_nxt = kind_follow;
      end
      KIND_WORD: begin
        first    = (req_i.cls != CLS_WORD);
        kind_nxt = kind_follow;
      end
      KIND_CR: begin
        first    = (req_i.cls != CLS_LF);
        kind_nxt = first ? kind_follow : KIND_NONE;
      end
      default: begin
        first    = 1'b1;
        kind_nxt = kind_follow;
      end
    endcase
  end

  assign count_shown = (first && (count_r != '1)) ? count_r + 1'b1 : count_r;
  assign count_nxt   = req_i.last ? '0 : count_shown;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_NONE;
      count_r <= '0;
    end else if (req_i.advance) begin
      kind_r  <= req_i.last ? KIND_NONE : kind_nxt;
      count_r <= count_nxt;
    end
  end

  assign rsp_o.first = first;
  assign rsp_o.kind  = kind_r;
  assign count_o     = count_shown;

endmodule

// File: rtl/core/text_pretokenizer_splitter_core.sv
// Top level of the text pretokenizer splitter: input stage, classifier, tracker, result stage.

// The block takes a text one byte per item and returns one result item per byte:
// the byte itself, its class, a mark telling whether it begins a new
// pre-tokenization chunk, the running chunk count of the text (including the
// chunk this byte belongs to) and a done flag on the last byte. A byte
// enters an input register, is classified and matched against the open chunk
// kind combinationally, and then lands in the result register, so one item
// is accepted every cycle while the output is not stalled, and each result is
// offered on out_ch from the result register. The one-cycle rate is set by
// the open-chunk state register, which is read and updated once per byte. The
// input and result registers let a new byte enter while a finished result
// still waits; in_ch.ready falls only when both are full and out_ch.ready is
// low. The chunk counter is COUNT_WIDTH bits wide and saturates; the reported
// chunk_total holds at 65535 when the counter runs past it. The byte marked
// last_of_text returns the open kind and the counter to their reset values.
module text_pretokenizer_splitter_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tps_in_if.sink    in_ch,
  tps_out_if.source out_ch
);
  import tps_pkg::*;

  // Input stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Result stage.
  logic                     out_valid_r;
  logic [BYTE_W-1:0]        out_byte_r;
  logic                     out_first_r;
  byte_class_t              out_cls_r;
  logic [SHOWN_COUNT_W-1:0] out_count_r;
  logic                     out_done_r;

  logic                     s2_open;
  logic                     s2_load;
  logic                     s1_open;
  logic                     in_take;
  byte_class_t              s1_cls;
  trk_req_t                 trk_req;
  trk_rsp_t                 trk_rsp;
  logic [COUNT_WIDTH-1:0]   trk_count;
  logic [SHOWN_COUNT_W-1:0] count_clip;

  // The result register frees up when empty or when its item is taken; the
  // input register frees up when empty or when its item moves on.
  assign s2_open = !out_valid_r || out_ch.ready;
  assign s2_load = s1_valid_r && s2_open;
  assign s1_open = !s1_valid_r || s2_open;
  assign in_take = in_ch.valid && s1_open;

  assign in_ch.ready = s1_open;

  tps_classifier u_classifier (
    .byte_i (s1_byte_r),
    .cls_o  (s1_cls)
  );

  // The tracker only moves its state when the item really enters the
  // result register, so stalls never repeat or drop an update.
  assign trk_req.advance = s2_load;
  assign trk_req.cls     = s1_cls;
  assign trk_req.last    = s1_last_r;

  tps_chunk_tracker #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (trk_req),
    .rsp_o   (trk_rsp),
    .count_o (trk_count)
  );

  // The reported count is 16 bits; a wider counter is clipped to all ones.
  generate
    if (COUNT_WIDTH > SHOWN_COUNT_W) begin : g_clip
      assign count_clip = (|trk_count[COUNT_WIDTH-1:SHOWN_COUNT_W]) ?
                          '1 : trk_count[SHOWN_COUNT_W-1:0];
    end else begin : g_extend
      assign count_clip = SHOWN_COUNT_W'(trk_count);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_open) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.text_byte;
      s1_last_r <= in_ch.last_of_text;
    end
    if (s2_load) begin
      out_byte_r  <= s1_byte_r;
      out_first_r <= trk_rsp.first;
      out_cls_r   <= s1_cls;
      out_count_r <= count_clip;
      out_done_r  <= s1_last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_out       = out_byte_r;
  assign out_ch.first_of_chunk = out_first_r;
  assign out_ch.byte_class     = out_cls_r;
  assign out_ch.chunk_total    = out_count_r;
  assign out_ch.text_done      = out_done_r;

`ifndef SYNTHESIS
  // After the last byte of a text moves on, no chunk is left open.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && s1_last_r |=> trk_rsp.kind == KIND_NONE)
    else $error("open chunk kind not cleared after last byte");

  // Outside a run of leading blanks, a byte of class other always begins a
  // chunk of its own.
  a_other_first: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && s1_cls == CLS_OTHER && trk_rsp.kind != KIND_SPACES |-> trk_rsp.first)
    else $error("other byte did not begin a chunk");

  // An LF continues a chunk only right after a CR or after leading blanks.
  a_lf_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && s1_cls == CLS_LF && trk_rsp.kind != KIND_CR &&
    trk_rsp.kind != KIND_SPACES |-> trk_rsp.first)
    else $error("LF joined a chunk not opened by CR");

  // A byte that continues a chunk belongs to a chunk that was counted.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_first_r |-> out_count_r != '0)
    else $error("continuing byte reported with zero chunk count");
`endif

endmodule
